>>> rtl/core/record_table_sort_search_delete_defines.svh
// Assertion macros shared by the record table RTL.
// No dependencies; include after the package is compiled.
`ifndef RECORD_TABLE_SORT_SEARCH_DELETE_DEFINES_SVH
`define RECORD_TABLE_SORT_SEARCH_DELETE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RTSSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RTSSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rtssd_pkg.sv
// Package for the record table: sizes, record type, codes and index helpers.
// No dependencies.
`timescale 1ns / 1ps

package rtssd_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WIDE_W   = CNT_W + 1;
    localparam int POS_W    = 7;
    localparam int RCNT_W   = 8;

    typedef struct packed {
        logic [63:0] name;
        logic [63:0] number;
        logic [63:0] address;
    } t_rec;

    typedef struct packed {
        logic shift;
        t_rec push;
    } t_ring_ctl;

    typedef enum logic [3:0] {
        OP_APPEND    = 4'd0,
        OP_FIND_NAME = 4'd1,
        OP_FIND_NUM  = 4'd2,
        OP_DEL_NAME  = 4'd3,
        OP_DEL_NUM   = 4'd4,
        OP_MODIFY    = 4'd5,
        OP_SORT_ASC  = 4'd6,
        OP_SORT_DESC = 4'd7,
        OP_READ      = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_SORT,
        ST_ALIGN,
        ST_FIN
    } t_state;

    function automatic logic below(input logic [IDX_W-1:0] t, input logic [CNT_W-1:0] c);
        return WIDE_W'(t) < WIDE_W'(c);
    endfunction

    function automatic logic at_count(input logic [IDX_W-1:0] t,
                                      input logic [CNT_W-1:0] c);
        return WIDE_W'(t) == WIDE_W'(c);
    endfunction

    function automatic logic is_last(input logic [IDX_W-1:0] t);
        return WIDE_W'(t) == WIDE_W'(CAPACITY - 1);
    endfunction

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] t);
        return IDX_W'(WIDE_W'(t) + WIDE_W'(1));
    endfunction

    function automatic logic [IDX_W-1:0] cnt_to_idx(input logic [CNT_W-1:0] c);
        return IDX_W'(c);
    endfunction

    function automatic logic ridx_hit(input logic [IDX_W-1:0] t, input logic [POS_W-1:0] r);
        return 32'(t) == 32'(r);
    endfunction

    function automatic logic sort_live(input logic [IDX_W-1:0] p, input logic [IDX_W-1:0] s,
                                       input logic [CNT_W-1:0] c);
        return (WIDE_W'(p) + WIDE_W'(s) + WIDE_W'(1)) < WIDE_W'(c);
    endfunction

    function automatic logic last_pass(input logic [IDX_W-1:0] p, input logic [CNT_W-1:0] c);
        return (WIDE_W'(p) + WIDE_W'(2)) == WIDE_W'(c);
    endfunction

    function automatic logic cnt_full(input logic [CNT_W-1:0] c);
        return WIDE_W'(c) >= WIDE_W'(CAPACITY);
    endfunction

    function automatic logic cnt_lt2(input logic [CNT_W-1:0] c);
        return WIDE_W'(c) < WIDE_W'(2);
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return CNT_W'(WIDE_W'(c) + WIDE_W'(1));
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return CNT_W'(WIDE_W'(c) - WIDE_W'(1));
    endfunction

    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] t);
        return POS_W'(t);
    endfunction

    function automatic logic [RCNT_W-1:0] to_rcnt(input logic [CNT_W-1:0] c);
        return RCNT_W'(c);
    endfunction

endpackage

>>> rtl/core/record_table_sort_search_delete.sv
// Record table top level: one item at a time. Append, find, delete, modify, read and unused
// codes walk the whole ring before the result is registered; the next item is taken after that.
// Sort of n >= 2 records: one ring rotation per pass, then a realigning rotation; fewer than
// two records finish without a pass. A stalled result holds the engine.
// Reset (synchronous, active low) empties the table and drops any pending result.
// Depends on rtssd_pkg, rtssd_cell and rtssd_engine.
`timescale 1ns / 1ps

module record_table_sort_search_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_op,
    input  logic [63:0] i_name_key,
    input  logic [63:0] i_number_key,
    input  logic [63:0] i_address_value,
    input  logic [6:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_position,
    output logic [63:0] o_out_name,
    output logic [63:0] o_out_number,
    output logic [63:0] o_out_address,
    output logic [7:0]  o_record_count
);

    rtssd_pkg::t_rec      w_ring [rtssd_pkg::CAPACITY];
    rtssd_pkg::t_ring_ctl w_ctl;

    for (genvar k = 0; k < rtssd_pkg::CAPACITY; k++) begin : g_cell
        if (k == rtssd_pkg::CAPACITY - 1) begin : g_tail
            rtssd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_ctl.shift),
                .i_rec   (w_ctl.push),
                .o_rec   (w_ring[k])
            );
        end else begin : g_body
            rtssd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_ctl.shift),
                .i_rec   (w_ring[k+1]),
                .o_rec   (w_ring[k])
            );
        end
    end

    rtssd_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_name_key      (i_name_key),
        .i_number_key    (i_number_key),
        .i_address_value (i_address_value),
        .i_read_index    (i_read_index),
        .i_head          (w_ring[0]),
        .i_next          (w_ring[1]),
        .o_ctl           (w_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_out_name      (o_out_name),
        .o_out_number    (o_out_number),
        .o_out_address   (o_out_address),
        .o_record_count  (o_record_count)
    );

endmodule

>>> rtl/core/rtssd_cell.sv
// One cell of the record ring: holds one record, loads from its neighbor (the tail cell from the engine).
// Depends on rtssd_pkg.
`timescale 1ns / 1ps

module rtssd_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  rtssd_pkg::t_rec   i_rec,
    output rtssd_pkg::t_rec   o_rec
);

    rtssd_pkg::t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

>>> rtl/core/rtssd_engine.sv
// Control engine of the record table: walks the ring, runs the sort passes,
// holds the result register. Depends on rtssd_pkg and the defines header.
`timescale 1ns / 1ps
`include "record_table_sort_search_delete_defines.svh"

module rtssd_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [3:0]            i_op,
    input  logic [63:0]           i_name_key,
    input  logic [63:0]           i_number_key,
    input  logic [63:0]           i_address_value,
    input  logic [6:0]            i_read_index,
    input  rtssd_pkg::t_rec       i_head,
    input  rtssd_pkg::t_rec       i_next,
    output rtssd_pkg::t_ring_ctl  o_ctl,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [6:0]            o_position,
    output logic [63:0]           o_out_name,
    output logic [63:0]           o_out_number,
    output logic [63:0]           o_out_address,
    output logic [7:0]            o_record_count
);

    rtssd_pkg::t_state                  r_state, n_state;
    rtssd_pkg::t_op                     r_op, n_op;
    rtssd_pkg::t_rec                    r_key, n_key;
    logic [rtssd_pkg::POS_W-1:0]        r_ridx, n_ridx;
    logic [rtssd_pkg::CNT_W-1:0]        r_count, n_count;
    logic [rtssd_pkg::IDX_W-1:0]        r_step, n_step;
    logic [rtssd_pkg::IDX_W-1:0]        r_pass, n_pass;
    logic [rtssd_pkg::IDX_W-1:0]        r_off, n_off;
    rtssd_pkg::t_rec                    r_hold, n_hold;
    logic                               r_found, n_found;
    logic [rtssd_pkg::IDX_W-1:0]        r_pos, n_pos;
    rtssd_pkg::t_rec                    r_res, n_res;
    rtssd_pkg::t_status                 r_status, n_status;
    logic                               r_out_valid, n_out_valid;
    rtssd_pkg::t_status                 r_o_status, n_o_status;
    logic [rtssd_pkg::POS_W-1:0]        r_o_pos, n_o_pos;
    rtssd_pkg::t_rec                    r_o_rec, n_o_rec;
    logic [rtssd_pkg::RCNT_W-1:0]       r_o_count, n_o_count;

    always_comb begin
        rtssd_pkg::t_op  v_op;
        rtssd_pkg::t_rec v_h;
        rtssd_pkg::t_rec v_mod;
        logic            v_live;
        logic            v_hit;
        logic            v_ooo;
        logic            v_by_name;

        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_ridx      = r_ridx;
        n_count     = r_count;
        n_step      = r_step;
        n_pass      = r_pass;
        n_off       = r_off;
        n_hold      = r_hold;
        n_found     = r_found;
        n_pos       = r_pos;
        n_res       = r_res;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_pos     = r_o_pos;
        n_o_rec     = r_o_rec;
        n_o_count   = r_o_count;
        o_ctl.shift = 1'b0;
        o_ctl.push  = i_head;
        v_op        = rtssd_pkg::t_op'(i_op);
        v_h         = i_head;
        v_mod       = '{name: i_head.name, number: r_key.number, address: r_key.address};
        v_live      = rtssd_pkg::below(r_step, r_count);
        v_by_name   = (r_op == rtssd_pkg::OP_FIND_NAME) || (r_op == rtssd_pkg::OP_DEL_NAME);
        v_hit       = 1'b0;
        v_ooo       = 1'b0;

        unique case (r_state)
            rtssd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = v_op;
                    n_key    = '{name: i_name_key, number: i_number_key,
                                 address: i_address_value};
                    n_ridx   = i_read_index;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_res    = '0;
                    n_step   = '0;
                    n_pass   = '0;
                    n_status = rtssd_pkg::STATUS_OK;
                    if (v_op == rtssd_pkg::OP_APPEND && rtssd_pkg::cnt_full(r_count)) begin
                        n_status = rtssd_pkg::STATUS_FULL;
                        n_state  = rtssd_pkg::ST_FIN;
                    end else if (v_op == rtssd_pkg::OP_SORT_ASC ||
                                 v_op == rtssd_pkg::OP_SORT_DESC) begin
                        n_state = rtssd_pkg::cnt_lt2(r_count) ? rtssd_pkg::ST_FIN
                                                              : rtssd_pkg::ST_SORT;
                    end else begin
                        n_state = rtssd_pkg::ST_RUN;
                    end
                end
            end
            rtssd_pkg::ST_RUN: begin
                o_ctl.shift = 1'b1;
                case (r_op)
                    rtssd_pkg::OP_APPEND: begin
                        if (rtssd_pkg::at_count(r_step, r_count)) begin
                            o_ctl.push = r_key;
                        end
                    end
                    rtssd_pkg::OP_FIND_NAME, rtssd_pkg::OP_FIND_NUM,
                    rtssd_pkg::OP_DEL_NAME, rtssd_pkg::OP_DEL_NUM: begin
                        v_hit = v_live && !r_found &&
                                (v_by_name ? (i_head.name == r_key.name)
                                           : (i_head.number == r_key.number));
                        if (v_hit) begin
                            n_found = 1'b1;
                            n_pos   = r_step;
                            n_res   = i_head;
                        end
                        if ((r_op == rtssd_pkg::OP_DEL_NAME || r_op == rtssd_pkg::OP_DEL_NUM)
                            && (r_found || v_hit)) begin
                            o_ctl.push = i_next;
                        end
                    end
                    rtssd_pkg::OP_MODIFY: begin
                        if (v_live && i_head.name == r_key.name) begin
                            o_ctl.push = v_mod;
                            if (!r_found) begin
                                n_found = 1'b1;
                                n_pos   = r_step;
                                n_res   = v_mod;
                            end
                        end
                    end
                    rtssd_pkg::OP_READ: begin
                        if (v_live && rtssd_pkg::ridx_hit(r_step, r_ridx)) begin
                            n_found = 1'b1;
                            n_pos   = r_step;
                            n_res   = i_head;
                        end
                    end
                    default: begin
                    end
                endcase
                if (rtssd_pkg::is_last(r_step)) begin
                    n_state = rtssd_pkg::ST_FIN;
                    case (r_op)
                        rtssd_pkg::OP_APPEND: begin
                            n_count = rtssd_pkg::cnt_inc(r_count);
                            n_pos   = rtssd_pkg::cnt_to_idx(r_count);
                            n_res   = r_key;
                        end
                        rtssd_pkg::OP_FIND_NAME, rtssd_pkg::OP_FIND_NUM,
                        rtssd_pkg::OP_MODIFY: begin
                            if (!n_found) begin
                                n_status = rtssd_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        rtssd_pkg::OP_DEL_NAME, rtssd_pkg::OP_DEL_NUM: begin
                            if (n_found) begin
                                n_count = rtssd_pkg::cnt_dec(r_count);
                            end else begin
                                n_status = rtssd_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        rtssd_pkg::OP_READ: begin
                            if (!n_found) begin
                                n_status = rtssd_pkg::STATUS_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_step = rtssd_pkg::inc_idx(r_step);
                end
            end
            rtssd_pkg::ST_SORT: begin
                o_ctl.shift = 1'b1;
                v_h = (r_step == '0) ? i_head : r_hold;
                if (rtssd_pkg::is_last(r_step)) begin
                    o_ctl.push = r_hold;
                    n_step     = '0;
                    if (rtssd_pkg::last_pass(r_pass, r_count)) begin
                        n_off   = rtssd_pkg::inc_idx(r_pass);
                        n_state = rtssd_pkg::ST_ALIGN;
                    end else begin
                        n_pass = rtssd_pkg::inc_idx(r_pass);
                    end
                end else begin
                    v_ooo = rtssd_pkg::sort_live(r_pass, r_step, r_count) &&
                            ((r_op == rtssd_pkg::OP_SORT_DESC) ? (v_h.name < i_next.name)
                                                               : (v_h.name > i_next.name));
                    o_ctl.push = v_ooo ? v_h : i_next;
                    n_hold     = v_ooo ? i_next : v_h;
                    n_step     = rtssd_pkg::inc_idx(r_step);
                end
            end
            rtssd_pkg::ST_ALIGN: begin
                o_ctl.shift = 1'b1;
                if (rtssd_pkg::is_last(r_off)) begin
                    n_off   = '0;
                    n_state = rtssd_pkg::ST_FIN;
                end else begin
                    n_off = rtssd_pkg::inc_idx(r_off);
                end
            end
            rtssd_pkg::ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_pos     = rtssd_pkg::to_pos(r_pos);
                    n_o_rec     = r_res;
                    n_o_count   = rtssd_pkg::to_rcnt(r_count);
                    n_state     = rtssd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rtssd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtssd_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_off       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_off       <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_ridx     <= n_ridx;
        r_step     <= n_step;
        r_pass     <= n_pass;
        r_hold     <= n_hold;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_res      <= n_res;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_rec    <= n_o_rec;
        r_o_count  <= n_o_count;
    end

    assign o_in_ready     = (r_state == rtssd_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_position     = r_o_pos;
    assign o_out_name     = r_o_rec.name;
    assign o_out_number   = r_o_rec.number;
    assign o_out_address  = r_o_rec.address;
    assign o_record_count = r_o_count;

    `RTSSD_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, !rtssd_pkg::cnt_full(r_count) || (r_count == rtssd_pkg::CNT_W'(rtssd_pkg::CAPACITY)), "count above capacity")
    `RTSSD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != rtssd_pkg::ST_IDLE, "accepted item left engine idle")
    `RTSSD_ASSERT_NOW(a_sort_count, i_clk, i_rst_n, r_state == rtssd_pkg::ST_SORT, !rtssd_pkg::cnt_lt2(r_count), "sort pass with fewer than two records")
    `RTSSD_ASSERT_NOW(a_align_off, i_clk, i_rst_n, r_state == rtssd_pkg::ST_ALIGN, r_off != '0, "ring realign from zero offset")

endmodule
